>>> sv/bbe_pkg.sv
// Package for the binary boundary extraction core.
// Holds sizes, the result record type and the image size clamp.
// No dependencies.
package bbe_pkg;

   localparam int MAX_SIZE   = 128;
   localparam int SIZE_CAP   = (MAX_SIZE < 128) ? MAX_SIZE : 128;
   localparam int COORD_W    = 7;
   localparam int SIZE_W     = 8;
   localparam int LINE_DEPTH = MAX_SIZE;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

   typedef enum logic {
      REG_IMAGE_SIZE = 1'b0,
      REG_UNUSED     = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic               pixel;
      logic               last;
      logic               frame_end;
   } result_type;

   function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] n;
      n = size;
      if (n == '0) begin
         n = SIZE_W'(1);
      end
      if (n > SIZE_W'(SIZE_CAP)) begin
         n = SIZE_W'(SIZE_CAP);
      end
      return n;
   endfunction

endpackage

>>> sv/binary_boundary_extraction_core.sv
// Top level of the binary boundary extraction core: counters, line memory,
// 3x3 window, result logic and a small result queue.
// Depends on bbe_pkg.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_ready  req_pixel_in
//   rsp       out         rsp_valid/rsp_ready  row, column, pixel, last, frame end
//   csr       in/out      psel/penable/pready  image_size at byte address 0
//
// One pixel is taken per cycle; its results are computed in the same cycle and
// written into a four-entry result queue, which presents one result per cycle
// while rsp_ready is high. The input stalls only while fewer than two queue
// entries are free, which happens on the last row of an image where most pixels
// give two results. Reset is synchronous and clears counters, window, queue and
// image_size to 8. The line memory needs no clearing pass.
module binary_boundary_extraction_core
   import bbe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_pixel_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COORD_W-1:0]  rsp_out_row,
   output logic [COORD_W-1:0]  rsp_out_column,
   output logic                rsp_pixel_out,
   output logic                rsp_last_of_item,
   output logic                rsp_frame_end,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   logic [SIZE_W-1:0]  size_ff;
   logic [SIZE_W-1:0]  size_in;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] row_in;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] col_in;
   logic [5:0]         window_ff;
   logic [5:0]         window_in;
   logic [1:0]         line_rd_ff;
   logic [1:0]         line_mem [LINE_DEPTH];

   result_type         fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff;
   logic [FIFO_CW-1:0] count_in;

   logic               cfg_write;
   logic               accept;
   logic               pop;
   logic [SIZE_W-1:0]  size_eff;
   logic [COORD_W-1:0] last_idx;
   logic               row_last;
   logic               col_last;
   logic               finish;
   logic               frame;
   logic [2:0]         col_new;
   logic               all_ones;
   logic [1:0]         num_push;
   result_type         inner_res;
   result_type         frame_res;
   result_type         entry0;
   result_type         entry1;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready
                      && (reg_index_type'(paddr[2]) == REG_IMAGE_SIZE);
   assign prdata    = (reg_index_type'(paddr[2]) == REG_IMAGE_SIZE)
                      ? CSR_DW'(size_ff) : '0;

   assign req_ready = (count_ff <= FIFO_CW'(FIFO_DEPTH - 2));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   assign size_eff  = effective_size(size_ff);
   assign last_idx  = COORD_W'(size_eff - SIZE_W'(1));
   assign row_last  = (row_ff == last_idx);
   assign col_last  = (col_ff == last_idx);
   assign finish    = (row_ff >= COORD_W'(2)) && (col_ff >= COORD_W'(2));
   assign frame     = (row_ff == '0) || (col_ff == '0) || row_last || col_last;

   assign col_new   = {req_pixel_in, line_rd_ff[1], line_rd_ff[0]};
   assign all_ones  = (window_ff == 6'h3F) && (col_new == 3'b111);
   assign num_push  = {1'b0, finish} + {1'b0, frame};

   always_comb begin
      inner_res.row       = row_ff - COORD_W'(1);
      inner_res.column    = col_ff - COORD_W'(1);
      inner_res.pixel     = all_ones ? 1'b0 : window_ff[1];
      inner_res.last      = !frame;
      inner_res.frame_end = 1'b0;
      frame_res.row       = row_ff;
      frame_res.column    = col_ff;
      frame_res.pixel     = req_pixel_in;
      frame_res.last      = 1'b1;
      frame_res.frame_end = row_last && col_last;
      entry0              = finish ? inner_res : frame_res;
      entry1              = frame_res;
   end

   always_comb begin
      size_in   = size_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      window_in = window_ff;
      if (cfg_write) begin
         size_in   = pwdata[SIZE_W-1:0];
         row_in    = '0;
         col_in    = '0;
         window_in = '0;
      end else if (accept) begin
         window_in = {window_ff[2:0], col_new};
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + COORD_W'(1);
         end else begin
            col_in = col_ff + COORD_W'(1);
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + FIFO_AW'(num_push);
         count_in  = count_ff + FIFO_CW'(num_push);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_AW'(1);
         count_in  = count_in - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_RESET;
         row_ff    <= '0;
         col_ff    <= '0;
         window_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         size_ff   <= size_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         window_ff <= window_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The read address is the column of the next pixel, so the line data for
   // that pixel is ready in line_rd_ff when it arrives.
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[LINE_AW'(col_ff)] <= {req_pixel_in, line_rd_ff[1]};
      end
      line_rd_ff <= line_mem[LINE_AW'(col_in)];
   end

   always_ff @(posedge clock) begin
      if (accept && (finish || frame)) begin
         fifo_ff[wr_ptr_ff] <= entry0;
      end
      if (accept && finish && frame) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= entry1;
      end
   end

   assign rsp_out_row      = fifo_ff[rd_ptr_ff].row;
   assign rsp_out_column   = fifo_ff[rd_ptr_ff].column;
   assign rsp_pixel_out    = fifo_ff[rd_ptr_ff].pixel;
   assign rsp_last_of_item = fifo_ff[rd_ptr_ff].last;
   assign rsp_frame_end    = fifo_ff[rd_ptr_ff].frame_end;

endmodule
